/* design/u16u8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_pkg: shared types and constants of the UTF-16 to UTF-8 encoder
// Holds the job record that passes from the classifier to the byte emitter,
// the Unicode range limits and the UTF-8 lead and continuation byte marks.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	// Most bytes that one code unit can cause: a flushed surrogate plus three bytes.
	localparam int unsigned MaxBytes = 6;
	localparam int unsigned CountW   = $clog2(MaxBytes + 1);
	localparam int unsigned IdxW     = $clog2(MaxBytes);

	// Range limits of a code unit.
	localparam logic [15:0] OneByteLimit = 16'h0080;
	localparam logic [15:0] TwoByteLimit = 16'h0800;
	localparam logic [15:0] HighSurBase  = 16'hD800;
	localparam logic [15:0] LowSurBase   = 16'hDC00;
	localparam logic [15:0] SurEnd       = 16'hE000;

	// UTF-8 byte marks.
	localparam logic [7:0] Lead2Mark = 8'b1100_0000;
	localparam logic [7:0] Lead3Mark = 8'b1110_0000;
	localparam logic [7:0] Lead4Mark = 8'b1111_0000;
	localparam logic [7:0] ContMark  = 8'b1000_0000;

	// Offset of the supplementary planes.
	localparam logic [20:0] SupplBase = 21'h010000;

	// One queued job: the bytes that one accepted transfer causes.
	typedef struct packed {
		logic [CountW-1:0]          count;
		logic [MaxBytes-1:0][7:0]   bytes;
		logic                       fin;
	} job_t;

	// Three-byte pattern of a 16-bit value.
	function automatic logic [2:0][7:0] three_bytes(input logic [15:0] u);
		logic [2:0][7:0] b;
		b[0] = Lead3Mark | {4'h0, u[15:12]};
		b[1] = ContMark  | {2'b00, u[11:6]};
		b[2] = ContMark  | {2'b00, u[5:0]};
		return b;
	endfunction

endpackage

/* design/u16u8_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_front: input classifier
// Accepts code units, keeps a held high surrogate, and turns each transfer
// into a job that lists the UTF-8 bytes it causes.
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [15:0]          code_unit,
	input  logic                 final_unit,
	output logic                 push,
	output u16u8_pkg::job_t      push_job,
	input  logic                 full
);
	import u16u8_pkg::*;

	logic                 pend_valid_q;
	logic [9:0]           pend_high_q;
	logic                 accept;
	logic                 is_high;
	logic                 is_low;
	logic                 pair;
	logic                 hold_new;
	logic [2:0][7:0]      held_b;
	logic [2:0][7:0]      main_b;
	logic [1:0]           main_n;
	logic [20:0]          cp;
	logic [CountW-1:0]    total_n;
	job_t                 job;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	assign is_high = (code_unit >= HighSurBase) && (code_unit < LowSurBase);
	assign is_low  = (code_unit >= LowSurBase) && (code_unit < SurEnd);
	assign pair    = pend_valid_q && is_low;
	assign held_b  = three_bytes({6'b110110, pend_high_q});
	assign cp      = SupplBase + {1'b0, pend_high_q, code_unit[9:0]};

	// Bytes of the new unit on its own.
	always_comb begin
		main_b   = three_bytes(code_unit);
		main_n   = 2'd3;
		hold_new = 1'b0;
		if (code_unit < OneByteLimit) begin
			main_b[0] = code_unit[7:0];
			main_n    = 2'd1;
		end else if (code_unit < TwoByteLimit) begin
			main_b[0] = Lead2Mark | {3'b000, code_unit[10:6]};
			main_b[1] = ContMark | {2'b00, code_unit[5:0]};
			main_n    = 2'd2;
		end else if (is_high && !final_unit) begin
			main_n   = 2'd0;
			hold_new = 1'b1;
		end
	end

	// Assemble the job: a surrogate pair, a flushed held unit followed by the new one, or the new unit alone.
	always_comb begin
		job       = '0;
		job.fin   = final_unit;
		if (pair) begin
			job.bytes[0] = Lead4Mark | {5'b00000, cp[20:18]};
			job.bytes[1] = ContMark | {2'b00, cp[17:12]};
			job.bytes[2] = ContMark | {2'b00, cp[11:6]};
			job.bytes[3] = ContMark | {2'b00, cp[5:0]};
			total_n      = CountW'(4);
		end else if (pend_valid_q) begin
			job.bytes[0] = held_b[0];
			job.bytes[1] = held_b[1];
			job.bytes[2] = held_b[2];
			job.bytes[3] = main_b[0];
			job.bytes[4] = main_b[1];
			job.bytes[5] = main_b[2];
			total_n      = CountW'(3) + CountW'(main_n);
		end else begin
			job.bytes[0] = main_b[0];
			job.bytes[1] = main_b[1];
			job.bytes[2] = main_b[2];
			total_n      = CountW'(main_n);
		end
		job.count = total_n;
	end

	assign push     = accept && (total_n != '0);
	assign push_job = job;

	// Held high surrogate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_high_q  <= '0;
		end else if (accept) begin
			pend_valid_q <= !pair && hold_new;
			pend_high_q  <= (!pair && hold_new) ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

/* design/u16u8_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_queue: two-entry job queue
// Decouples the classifier from the byte emitter so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
module u16u8_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  u16u8_pkg::job_t      push_job,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output u16u8_pkg::job_t      head_job
);
	import u16u8_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head_job   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/u16u8_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_back: byte emitter
// Walks the job at the queue head one byte per cycle, while the output is not
// stalled, into an output register and marks the last byte of each job and of each string.
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  u16u8_pkg::job_t      head_job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 run_end,
	output logic                 string_end
);
	import u16u8_pkg::*;

	logic [IdxW-1:0] idx_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            run_end_q;
	logic            string_end_q;
	logic            load;
	logic            last;

	assign load = head_valid && (!out_valid_q || !out_stall);
	assign last = CountW'(idx_q) == (head_job.count - CountW'(1));
	assign pop  = load && last;

	// Byte index within the current job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last ? '0 : idx_q + IdxW'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head_job.bytes[idx_q];
			run_end_q    <= last;
			string_end_q <= last && head_job.fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

endmodule

/* design/utf16_to_utf8_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder: UTF-16 code units in, UTF-8 bytes out
// A classifier turns each code unit into a list of bytes, a two-entry queue
// holds the lists, and an emitter sends them out one byte per transfer.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_stall    code_unit[15:0], final_unit
//   output    out_valid/out_stall  out_byte[7:0], run_end, string_end
//
// The output sends one byte per cycle while it is not stalled. A unit causes
// up to six bytes; a held high surrogate causes none until the next unit.
// A unit is taken whenever the two-entry job queue has room, so input and
// output run concurrently. A unit's bytes pass the job queue, then the output
// register. Reset clears the held surrogate, queue and output valid bit.
// A stalled output holds its byte; input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        string_end
);
	import u16u8_pkg::*;

	logic push;
	logic pop;
	logic full;
	logic head_valid;
	job_t push_job;
	job_t head_job;

	// Classifier.
	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.push       (push),
		.push_job   (push_job),
		.full       (full)
	);

	// Job queue.
	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Byte emitter.
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule

/* tb/utf16_to_utf8_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16u8_checker: byte stream checker for the UTF-16 to UTF-8 encoder
// Watches both channels. Each accepted code unit is run through a local
// encoder that keeps its own copy of the held high surrogate. The bytes it
// predicts are queued, and every accepted output byte is compared field by
// field with the oldest one in the queue.
// ----------------------------------------------------------------------------
module u16u8_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        final_unit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        run_end,
	input  logic        string_end,
	output int          fail_count,
	output int          pending_count,
	output int          bytes_checked,
	output int          pairs_joined
);
	import u16u8_pkg::*;

	// One predicted UTF-8 byte with its two end marks.
	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       string_end;
	} utf8_byte_t;

	utf8_byte_t utf8_q[$];
	logic [9:0] held_high;
	logic       held_valid;

	function automatic void queue_byte(input logic [7:0] data);
		utf8_byte_t b;
		b.data       = data;
		b.run_end    = 1'b0;
		b.string_end = 1'b0;
		utf8_q = {utf8_q, b};
	endfunction

	// Three-byte form of any 16-bit value, lone surrogates included.
	function automatic void queue_three(input logic [15:0] u);
		queue_byte(Lead3Mark | {4'h0, u[15:12]});
		queue_byte(ContMark | {2'b00, u[11:6]});
		queue_byte(ContMark | {2'b00, u[5:0]});
	endfunction

	// Encodes one code unit and appends the bytes that it causes.
	function automatic void predict_unit(input logic [15:0] u, input logic fin);
		int         base_size;
		logic       is_high;
		logic       is_low;
		logic [20:0] cp;
		utf8_byte_t tail;
		base_size = utf8_q.size();
		is_high   = (u >= HighSurBase) && (u < LowSurBase);
		is_low    = (u >= LowSurBase) && (u < SurEnd);
		if (held_valid && is_low) begin
			// A held high surrogate and this low one form a supplementary code point.
			cp = SupplBase + {1'b0, held_high, u[9:0]};
			queue_byte(Lead4Mark | {5'b00000, cp[20:18]});
			queue_byte(ContMark | {2'b00, cp[17:12]});
			queue_byte(ContMark | {2'b00, cp[11:6]});
			queue_byte(ContMark | {2'b00, cp[5:0]});
			held_valid = 1'b0;
			pairs_joined++;
		end else begin
			// A held surrogate that finds no partner goes out on its own first.
			if (held_valid) begin
				queue_three({6'b110110, held_high});
				held_valid = 1'b0;
			end
			if (u < OneByteLimit) begin
				queue_byte(u[7:0]);
			end else if (u < TwoByteLimit) begin
				queue_byte(Lead2Mark | {3'b000, u[10:6]});
				queue_byte(ContMark | {2'b00, u[5:0]});
			end else if (is_high && !fin) begin
				held_high  = u[9:0];
				held_valid = 1'b1;
			end else begin
				queue_three(u);
			end
		end
		// The last byte of this unit carries the end marks.
		if (utf8_q.size() > base_size) begin
			tail            = utf8_q[utf8_q.size() - 1];
			tail.run_end    = 1'b1;
			tail.string_end = fin;
			utf8_q[utf8_q.size() - 1] = tail;
		end
	endfunction

	// Prediction on input transfers, comparison on output transfers.
	always @(posedge clk or negedge arst_n) begin
		utf8_byte_t want;
		if (!arst_n) begin
			utf8_q.delete();
			held_high     = '0;
			held_valid    = 1'b0;
			fail_count    = 0;
			pending_count = 0;
			bytes_checked = 0;
			pairs_joined  = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_unit(code_unit, final_unit);
			end
			if (out_valid && !out_stall) begin
				if (utf8_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%0t: unexpected byte %02h run_end %0b string_end %0b",
							$realtime, out_byte, run_end, string_end);
					end
				end else begin
					want = utf8_q.pop_front();
					bytes_checked++;
					if (out_byte !== want.data || run_end !== want.run_end ||
						string_end !== want.string_end) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: byte mismatch, expected %02h/%0b/%0b, got %02h/%0b/%0b",
								$realtime, want.data, want.run_end, want.string_end,
								out_byte, run_end, string_end);
						end
					end
				end
			end
			pending_count = utf8_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level of the UTF-16 to UTF-8 encoder testbench
// Drives code units into the encoder, starting with boundary values and
// surrogate corner cases and going on with random strings that are mostly
// well-formed text. Both channels idle at random; the receiver also holds
// off once for a long stretch. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb;
	import u16u8_pkg::*;

	localparam int WatchdogLimit = 2000;
	localparam int HoldCycles    = 100;
	localparam int DirectedUnits = 25;
	localparam int RandomUnits   = 235;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        final_unit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        run_end;
	logic        string_end;

	logic calm     = 1'b0;
	logic hold_req = 1'b0;
	int   units_sent   = 0;
	int   strings_sent = 0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pending_count;
	int   bytes_checked;
	int   pairs_joined;

	utf16_to_utf8_encoder i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

	u16u8_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_unit     (code_unit),
		.final_unit    (final_unit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.run_end       (run_end),
		.string_end    (string_end),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.bytes_checked (bytes_checked),
		.pairs_joined  (pairs_joined)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HoldCycles;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall = 1'b1;
				hold_left--;
			end else begin
				out_stall = !calm && ($urandom_range(99) < 15);
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WatchdogLimit) begin
				$display("Timeout: no transfer for %0d cycles", WatchdogLimit);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offers one code unit and returns once its transfer has taken place.
	task automatic put_unit(input logic [15:0] u, input logic fin);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		code_unit  = u;
		final_unit = fin;
		do @(posedge clk); while (!(in_valid && !in_stall));
		units_sent++;
	endtask

	// Stops offering and waits until every predicted byte has come out.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_count == 0);
	endtask

	// One code unit outside any surrogate pair, mostly of the common classes.
	function automatic logic [15:0] random_unit();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35) begin
			return 16'($urandom_range(0, 16'h007F));
		end else if (pick < 55) begin
			return 16'($urandom_range(16'h0080, 16'h07FF));
		end else if (pick < 65) begin
			return 16'($urandom_range(16'h0800, 16'hD7FF));
		end else if (pick < 75) begin
			return 16'($urandom_range(16'hE000, 16'hFFFF));
		end else if (pick < 83) begin
			return HighSurBase | 16'($urandom_range(0, 1023));
		end else if (pick < 91) begin
			return LowSurBase | 16'($urandom_range(0, 1023));
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// A random string of one to nine units, the last one flagged final.
	task automatic send_string();
		logic [15:0] units[$];
		int          len;
		int          k;
		len = $urandom_range(1, 8);
		while (units.size() < len) begin
			if ($urandom_range(99) < 25) begin
				units = {units, HighSurBase | 16'($urandom_range(0, 1023)),
					LowSurBase | 16'($urandom_range(0, 1023))};
			end else begin
				units = {units, random_unit()};
			end
		end
		for (k = 0; k < units.size(); k++) begin
			put_unit(units[k], k == units.size() - 1);
		end
		strings_sent++;
	endtask

	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		code_unit  = '0;
		final_unit = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Class boundaries of one, two and three byte units.
		put_unit(16'h0000, 1'b0);
		put_unit(16'h007F, 1'b0);
		put_unit(16'h0080, 1'b0);
		put_unit(16'h07FF, 1'b0);
		put_unit(16'h0800, 1'b0);
		put_unit(16'hD7FF, 1'b0);
		put_unit(16'hE000, 1'b0);
		put_unit(16'hFFFF, 1'b1);
		// Lowest and highest surrogate pairs, the second one ending a string.
		put_unit(16'hD800, 1'b0);
		put_unit(16'hDC00, 1'b0);
		put_unit(16'hDBFF, 1'b0);
		put_unit(16'hDFFF, 1'b1);
		// A held surrogate flushed by an ASCII unit and by a three-byte unit.
		put_unit(16'hDABC, 1'b0);
		put_unit(16'h0041, 1'b0);
		put_unit(16'hDB01, 1'b0);
		put_unit(16'hABCD, 1'b0);
		// High after high: the first is flushed, the second pairs up.
		put_unit(16'hD834, 1'b0);
		put_unit(16'hD835, 1'b0);
		put_unit(16'hDD1E, 1'b0);
		// Lone low surrogate, then a high surrogate that ends a string.
		put_unit(16'hDE00, 1'b0);
		put_unit(16'hD912, 1'b1);
		// Held surrogate flushed by a final two-byte unit and by a final high one.
		put_unit(16'hD8AA, 1'b0);
		put_unit(16'h05D0, 1'b1);
		put_unit(16'hDA55, 1'b0);
		put_unit(16'hDB66, 1'b1);
		drain();

		// Random strings: free running, then a calm stretch, then a long hold-off.
		while (units_sent < DirectedUnits + 90) send_string();
		calm = 1'b1;
		while (units_sent < DirectedUnits + 140) send_string();
		calm     = 1'b0;
		hold_req = 1'b1;
		while (units_sent < DirectedUnits + 190) send_string();
		drain();
		while (units_sent < DirectedUnits + RandomUnits) send_string();
		drain();
		repeat (10) @(posedge clk);

		$display("Sent %0d code units in %0d strings; %0d surrogate pairs joined.",
			units_sent, strings_sent, pairs_joined);
		$display("Checked %0d UTF-8 bytes under random idling and a long output hold-off.",
			bytes_checked);
		if (fail_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
design/u16u8_pkg.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_encoder.sv
tb/utf16_to_utf8_checker.sv
tb/tb.sv
